/* src/kmp_pkg.sv */
// Shared types and constants for the k-transaction max-profit block.
package kmp_pkg;

   localparam int PriceW  = 16;
   localparam int ProfitW = 32;
   localparam int BuyW    = 34;
   localparam int LimitW  = 5;

   localparam logic [LimitW-1:0]         LIMIT_RESET = 5'd2;
   localparam logic signed [BuyW-1:0]    BUY_NONE    = {1'b1, {(BuyW-1){1'b0}}};
   localparam logic signed [BuyW-1:0]    SELL_MAX    = {2'b00, {ProfitW{1'b1}}};

   typedef struct packed {
      logic [PriceW-1:0] price;
      logic              last_day;
   } req_type;

   typedef struct packed {
      logic [ProfitW-1:0] best_profit;
      logic               series_end;
   } rsp_type;

   // One price sample moving down the chain, with the sell profit of the
   // cell it just left.
   typedef struct packed {
      logic               valid;
      logic               last_day;
      logic [PriceW-1:0]  price;
      logic [ProfitW-1:0] sell;
   } tok_type;

endpackage

/* src/k_transaction_max_profit.sv */
// Top level: k-transaction max profit over a streamed price series.
//
//   port group   direction   carries
//   req_*        in          price sample and last-day flag, one word per day
//   rsp_*        out         running best profit and series-end flag
//   csr_*        in          transaction limit k (5 bits)
//
// One word enters per cycle while the chain is not held; it walks through the
// MAX_CELLS cell registers, and its result is then held in the output register.
// Cells above k pass the sell profit through, so the tail carries sell[k], or sell[MAX_CELLS] when k exceeds MAX_CELLS.
// Reset clears every cell at once and sets k to 2.
// A held result stalls the whole chain only when the tail holds a word.
module k_transaction_max_profit #(
   parameter int MAX_CELLS  = 16,
   parameter int PRICE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  kmp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output kmp_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [kmp_pkg::LimitW-1:0] csr_data
);

   localparam logic [kmp_pkg::PriceW-1:0] PriceMask =
      (PRICE_BITS >= kmp_pkg::PriceW) ? {kmp_pkg::PriceW{1'b1}}
                                      : 16'((17'd1 << PRICE_BITS) - 17'd1);

   logic [kmp_pkg::LimitW-1:0] limit_ff, limit_in;
   kmp_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       advance;
   kmp_pkg::tok_type           chain [0:MAX_CELLS];

   assign chain[0].valid    = req_valid;
   assign chain[0].last_day = req_data.last_day;
   assign chain[0].price    = req_data.price & PriceMask;
   assign chain[0].sell     = '0;

   // hold the chain only when the tail word has nowhere to go
   assign advance   = !chain[MAX_CELLS].valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   for (genvar j = 1; j <= MAX_CELLS; j++) begin : g_cell
      kmp_cell #(
         .CELL_INDEX(j)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .limit   (limit_ff),
         .up_tok  (chain[j-1]),
         .down_tok(chain[j])
      );
   end

   always_comb begin
      limit_in     = limit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && chain[MAX_CELLS].valid) begin
         rsp_valid_in       = 1'b1;
         rsp_in.best_profit = chain[MAX_CELLS].sell;
         rsp_in.series_end  = chain[MAX_CELLS].last_day;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= kmp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/kmp_cell.sv */
// One transaction cell: best buy and sell profit for one transaction count.
module kmp_cell #(
   parameter int CELL_INDEX = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [kmp_pkg::LimitW-1:0]    limit,
   input  kmp_pkg::tok_type              up_tok,
   output kmp_pkg::tok_type              down_tok
);

   logic signed [kmp_pkg::BuyW-1:0] buy_ff, buy_in;
   logic [kmp_pkg::ProfitW-1:0]     sell_ff, sell_in;
   kmp_pkg::tok_type                tok_ff, tok_in;

   logic                            active;
   logic signed [kmp_pkg::BuyW-1:0] price_ext, cand_buy, new_buy;
   logic signed [kmp_pkg::BuyW-1:0] cand_sell, cand_sat, sell_ext;
   logic [kmp_pkg::ProfitW-1:0]     new_sell;

   assign active = int'(limit) >= CELL_INDEX;

   always_comb begin
      price_ext = signed'({18'b0, up_tok.price});
      sell_ext  = signed'({2'b0, sell_ff});
      cand_buy  = signed'({2'b0, up_tok.sell}) - price_ext;
      new_buy   = (cand_buy > buy_ff) ? cand_buy : buy_ff;
      cand_sell = new_buy + price_ext;
      cand_sat  = (cand_sell > kmp_pkg::SELL_MAX) ? kmp_pkg::SELL_MAX : cand_sell;
      new_sell  = (cand_sat > sell_ext) ? cand_sat[kmp_pkg::ProfitW-1:0] : sell_ff;

      buy_in  = buy_ff;
      sell_in = sell_ff;
      tok_in  = tok_ff;
      if (advance) begin
         tok_in = up_tok;
         if (active) begin
            tok_in.sell = new_sell;
         end
         if (up_tok.valid) begin
            // last sample of a series leaves the cell empty behind it
            if (up_tok.last_day) begin
               buy_in  = kmp_pkg::BUY_NONE;
               sell_in = '0;
            end else if (active) begin
               buy_in  = new_buy;
               sell_in = new_sell;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buy_ff       <= kmp_pkg::BUY_NONE;
         sell_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         buy_ff       <= buy_in;
         sell_ff      <= sell_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.last_day <= tok_in.last_day;
      tok_ff.price    <= tok_in.price;
      tok_ff.sell     <= tok_in.sell;
   end

   assign down_tok = tok_ff;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for k_transaction_max_profit: price series checked against a k-cell profit predictor.
module tb_top;

   localparam int CELLS        = 16;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = CELLS + 4;
   localparam int RANDOM_ITEMS = 820;

   typedef logic signed [kmp_pkg::BuyW+1:0] wide_type;
   typedef logic [kmp_pkg::LimitW-1:0]      limit_type;
   typedef enum int {SHAPE_NOISE, SHAPE_WALK, SHAPE_RAMP, SHAPE_SWING} shape_type;

   class profit_scoreboard_type #(int NCELLS = 16);
      limit_type                       limit;
      logic signed [kmp_pkg::BuyW-1:0] buy_best [1:NCELLS];
      logic [kmp_pkg::ProfitW-1:0]     sell_best [1:NCELLS];
      kmp_pkg::rsp_type                expected_answers [$];
      int unsigned                     errors;
      int unsigned                     prices_seen;
      int unsigned                     answers_seen;

      function new();
         limit = kmp_pkg::LIMIT_RESET;
         errors = 0;
         prices_seen = 0;
         answers_seen = 0;
         clear_cells();
      endfunction

      function void clear_cells();
         for (int j = 1; j <= NCELLS; j++) begin
            buy_best[j] = kmp_pkg::BUY_NONE;
            sell_best[j] = '0;
         end
      endfunction

      function void set_limit(limit_type value);
         limit = value;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      // walk one price through cells 1..k (at most NCELLS), buy before sell in each cell
      function kmp_pkg::rsp_type next_best_profit(kmp_pkg::req_type word);
         wide_type         price_w;
         wide_type         cand;
         int               cells;
         kmp_pkg::rsp_type answer;
         price_w = wide_type'(word.price);
         cells = (limit > NCELLS) ? NCELLS : int'(limit);
         for (int j = 1; j <= cells; j++) begin
            if (j == 1) cand = -price_w;
            else cand = wide_type'(sell_best[j-1]) - price_w;
            if (cand > wide_type'(buy_best[j])) buy_best[j] = cand[kmp_pkg::BuyW-1:0];
            cand = wide_type'(buy_best[j]) + price_w;
            if (cand > wide_type'(kmp_pkg::SELL_MAX)) cand = wide_type'(kmp_pkg::SELL_MAX);
            if (cand > wide_type'(sell_best[j])) sell_best[j] = cand[kmp_pkg::ProfitW-1:0];
         end
         if (cells >= 1) answer.best_profit = sell_best[cells];
         else answer.best_profit = '0;
         answer.series_end = word.last_day;
         // series over: drop all cell state
         if (word.last_day) clear_cells();
         return answer;
      endfunction

      function void note_price(kmp_pkg::req_type word);
         prices_seen++;
         expected_answers.push_back(next_best_profit(word));
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("tb_top: mismatch: %s", what);
      endtask

      task check_answer(kmp_pkg::rsp_type got);
         kmp_pkg::rsp_type want;
         answers_seen++;
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("answer %0d arrived with nothing expected",
                                      got.best_profit));
            return;
         end
         want = expected_answers.pop_front();
         if (got.best_profit !== want.best_profit)
            report_mismatch($sformatf("answer %0d: best_profit %0d, want %0d",
                                      answers_seen, got.best_profit, want.best_profit));
         if (got.series_end !== want.series_end)
            report_mismatch($sformatf("answer %0d: series_end %b, want %b",
                                      answers_seen, got.series_end, want.series_end));
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kmp_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kmp_pkg::rsp_type  rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   limit_type         csr_data  = '0;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left          = 0;
   int unsigned cycles             = 0;

   profit_scoreboard_type #(CELLS) board;

   k_transaction_max_profit #(
      .MAX_CELLS (CELLS),
      .PRICE_BITS(kmp_pkg::PriceW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_answer(rsp_data);
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
   end

   task automatic send_price(input logic [kmp_pkg::PriceW-1:0] price, input logic last_day);
      kmp_pkg::req_type word;
      word.price = price;
      word.last_day = last_day;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      board.note_price(word);
   endtask

   task automatic drain_results();
      if (board.pending() != 0) begin
         req_valid <= 1'b0;
         while (board.pending() != 0) @(posedge clock);
      end
   endtask

   task automatic write_limit(input limit_type value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_limit(value);
   endtask

   function automatic limit_type pick_limit();
      case ($urandom_range(9))
         0: return '0;
         1: return limit_type'(1);
         2: return limit_type'(CELLS);
         3: return limit_type'($urandom_range(31, CELLS + 1));
         default: return limit_type'($urandom_range(CELLS, 1));
      endcase
   endfunction

   task automatic run_series(input int length, input shape_type shape, input bit change_limit);
      int level;
      level = (shape == SHAPE_RAMP) ? int'($urandom_range(2000)) : int'($urandom_range(65535));
      for (int i = 0; i < length; i++) begin
         if (change_limit && i > 0 && i == length / 2) write_limit(pick_limit());
         case (shape)
            SHAPE_NOISE: level = $urandom_range(65535);
            SHAPE_WALK:  level = level + int'($urandom_range(4000)) - 2000;
            SHAPE_RAMP:  level = level + int'($urandom_range(3000)) - 500;
            default:     level = (i % 2 == 1) ? 65535 - int'($urandom_range(15))
                                              : int'($urandom_range(15));
         endcase
         if (level < 0) level = 0;
         if (level > 65535) level = 65535;
         send_price(level[kmp_pkg::PriceW-1:0], i == length - 1);
      end
   endtask

   initial begin
      int unsigned target;
      int          length;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset limit of two, full swings between the price extremes
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b0);
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b1);
      // zero limit: answer stays zero
      write_limit(5'd0);
      send_price(16'd100, 1'b0);
      send_price(16'hFFFF, 1'b1);
      // limit above the cell count
      write_limit(5'd31);
      send_price(16'h5555, 1'b0);
      send_price(16'hAAAA, 1'b0);
      send_price(16'h0001, 1'b0);
      send_price(16'hFFFE, 1'b1);
      write_limit(5'd1);
      send_price(16'hFFFF, 1'b0);
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b1);
      write_limit(limit_type'(CELLS));
      for (int i = 0; i < 6; i++) send_price((i % 2 == 1) ? 16'hFFFF : 16'h0000, i == 5);
      // change the limit mid-series; cells keep their values
      write_limit(5'd3);
      send_price(16'd10, 1'b0);
      send_price(16'd500, 1'b0);
      write_limit(5'd1);
      send_price(16'd5, 1'b0);
      send_price(16'd900, 1'b0);
      write_limit(5'd17);
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 50;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 50;
            end
            default: begin
               sender_idle_pct = 32;
               receiver_stall_pct = 32;
            end
         endcase
         if (phase == 0) begin
            // hold the output long enough for the chain to fill and stall the input
            write_limit(limit_type'(CELLS));
            hold_left = 400;
            run_series(60, SHAPE_NOISE, 1'b0);
            drain_results();
         end
         target = board.prices_seen + RANDOM_ITEMS / 4;
         while (board.prices_seen < target) begin
            if ($urandom_range(3) == 0) write_limit(pick_limit());
            length = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
            run_series(length, shape_type'($urandom_range(3)), $urandom_range(4) == 0);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb_top: %0d prices in, %0d answers checked, %0d mismatches",
               board.prices_seen, board.answers_seen, board.errors);
      $display("tb_top: covered limits 0 to 31, mid-series limit changes, long output stall");
      if (board.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
